FILE: hw/rtl/index_pool_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Index pool allocator assertion macros
// Shared property forms for the concurrent checks of the allocator core.
// ----------------------------------------------------------------------------
`ifndef INDEX_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define INDEX_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ipa_pkg.sv
// ----------------------------------------------------------------------------
// Index pool allocator package
// Field widths, request and status codes and the types shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipa_pkg;

    localparam int REQ_W  = 2;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;
    localparam int CFG_W  = 7;
    localparam int CFGA_W = 1;

    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CNT_W-1:0] MAX_SIZE_RST = 7'd64;

    localparam logic [CFGA_W-1:0] CFG_MAX_SIZE  = 1'b0;
    localparam logic [CFGA_W-1:0] CFG_INIT_SIZE = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_LIST    = 2'd2
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_BAD_RELEASE = 2'd2,
        ST_EMPTY       = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_LIST
    } t_bk_state;

    typedef struct packed {
        t_req             req;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q2b;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] slot_index;
        logic [CNT_W-1:0] active_total;
        logic [CNT_W-1:0] pool_capacity;
        logic             last;
    } t_result;

endpackage

FILE: hw/rtl/ipa_req_if.sv
// ----------------------------------------------------------------------------
// Index pool allocator request channel
// Valid/ready channel that carries one request to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipa_req_if
    import ipa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] entry_index;

    modport source (output valid, output req_type, output entry_index, input ready);
    modport sink   (input valid, input req_type, input entry_index, output ready);
endinterface

FILE: hw/rtl/ipa_rsp_if.sv
// ----------------------------------------------------------------------------
// Index pool allocator result channel
// Valid/ready channel that carries one result from the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipa_rsp_if
    import ipa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] slot_index;
    logic [CNT_W-1:0] active_total;
    logic [CNT_W-1:0] pool_capacity;
    logic             last;

    modport source (output valid, output status, output slot_index, output active_total,
                    output pool_capacity, output last, input ready);
    modport sink   (input valid, input status, input slot_index, input active_total,
                    input pool_capacity, input last, output ready);
endinterface

FILE: hw/rtl/ipa_front.sv
// ----------------------------------------------------------------------------
// Index pool allocator front end
// Accepts requests, drops unknown request codes and queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipa_front
    import ipa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipa_req_if.sink    i_req,
    output t_q2b       o_q,
    input  logic       i_pop
);

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    logic known_code;
    logic push;
    logic pop;
    t_cmd in_cmd;

    assign i_req.ready = (r_count != QCNT_W'(Q_DEPTH));
    assign known_code  = i_req.req_type inside {REQ_ACQUIRE, REQ_RELEASE, REQ_LIST};
    assign push        = i_req.valid && i_req.ready && known_code;
    assign pop         = i_pop && (r_count != '0);
    assign in_cmd.req  = t_req'(i_req.req_type);
    assign in_cmd.idx  = i_req.entry_index;

    assign o_q.valid = (r_count != '0);
    assign o_q.cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

FILE: hw/rtl/ipa_back.sv
// ----------------------------------------------------------------------------
// Index pool allocator back end
// Holds the pool state, executes queued requests and registers the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipa_back
    import ipa_pkg::*;
#(
    parameter int POOL_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q2b              i_q,
    output logic              o_pop,
    input  logic              i_cfg_we,
    input  logic [CFGA_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out
);

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);

    function automatic logic [IDX_W-1:0] enc_onehot(input logic [POOL_DEPTH-1:0] oh);
        logic [IDX_W-1:0] res;
        res = '0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            if (oh[i]) begin
                res = res | IDX_W'(i);
            end
        end
        return res;
    endfunction

    t_bk_state             r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [POOL_DEPTH-1:0] r_scan, n_scan;
    logic [POOL_DEPTH-1:0] r_used, n_used;
    logic [CNT_W-1:0]      r_cap, n_cap;
    logic [CNT_W-1:0]      r_active, n_active;
    logic [CNT_W-1:0]      r_max, n_max;
    t_result               r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [POOL_DEPTH-1:0] cap_mask;
    logic [POOL_DEPTH-1:0] free_map;
    logic [POOL_DEPTH-1:0] free_low;
    logic [POOL_DEPTH-1:0] list_rem;
    logic [POOL_DEPTH-1:0] list_low;
    logic [CNT_W-1:0]      lim;
    logic [CNT_W:0]        grow_sum;
    logic [CNT_W-1:0]      grown;
    logic [CNT_W-1:0]      new_cap;
    logic [CNT_W-1:0]      init_cap;
    logic                  rel_in_range;
    logic                  rel_used;
    logic                  out_free;

    always_comb begin
        for (int i = 0; i < POOL_DEPTH; i++) begin
            cap_mask[i] = (CNT_W'(i) < r_cap);
        end
    end

    assign free_map = ~r_used & cap_mask;
    assign free_low = free_map & (~free_map + 1'b1);
    assign list_rem = r_used & r_scan;
    assign list_low = list_rem & (~list_rem + 1'b1);

    assign lim      = (r_max < DEPTH_C) ? r_max : DEPTH_C;
    assign grow_sum = {1'b0, r_cap} + {1'b0, r_cap} + {2'b00, r_cap[CNT_W-1:1]};
    assign grown    = (grow_sum > {1'b0, lim}) ? lim : grow_sum[CNT_W-1:0];
    assign new_cap  = (grown > r_cap) ? grown : r_cap;
    assign init_cap = (i_cfg_data < lim) ? i_cfg_data : lim;

    assign rel_in_range = ({1'b0, r_cmd.idx} < r_cap) && ({1'b0, r_cmd.idx} < DEPTH_C);
    assign rel_used     = rel_in_range ? r_used[r_cmd.idx[IW-1:0]] : 1'b0;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_scan      = r_scan;
        n_used      = r_used;
        n_cap       = r_cap;
        n_active    = r_active;
        n_max       = r_max;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (i_q.valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q.cmd;
                    n_scan  = cap_mask;
                    n_state = (i_q.cmd.req == REQ_LIST) ? BK_LIST : BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    n_out.last       = 1'b1;
                    n_out.status     = ST_OK;
                    n_out.slot_index = '0;
                    case (r_cmd.req)
                        REQ_ACQUIRE: begin
                            if (free_map != '0) begin
                                n_used                   = r_used | free_low;
                                n_active                 = r_active + 1'b1;
                                n_out.slot_index         = enc_onehot(free_low);
                            end else if (new_cap > r_cap) begin
                                n_cap                    = new_cap;
                                n_used[r_cap[IW-1:0]]    = 1'b1;
                                n_active                 = r_active + 1'b1;
                                n_out.slot_index         = r_cap[IDX_W-1:0];
                            end else begin
                                n_out.status             = ST_EXHAUSTED;
                            end
                        end
                        REQ_RELEASE: begin
                            if (rel_used) begin
                                n_used[r_cmd.idx[IW-1:0]] = 1'b0;
                                if (r_active != '0) begin
                                    n_active = r_active - 1'b1;
                                end
                            end else begin
                                n_out.status = ST_BAD_RELEASE;
                            end
                        end
                        default: begin
                            n_out.status = ST_EMPTY;
                        end
                    endcase
                    n_out.active_total  = n_active;
                    n_out.pool_capacity = n_cap;
                    n_out_valid         = 1'b1;
                    n_state             = BK_IDLE;
                end
            end
            BK_LIST: begin
                if (out_free) begin
                    n_out.active_total  = r_active;
                    n_out.pool_capacity = r_cap;
                    n_out_valid         = 1'b1;
                    if (list_rem == '0) begin
                        n_out.status     = ST_EMPTY;
                        n_out.slot_index = '0;
                        n_out.last       = 1'b1;
                        n_state          = BK_IDLE;
                    end else begin
                        n_out.status     = ST_OK;
                        n_out.slot_index = enc_onehot(list_low);
                        n_out.last       = ((list_rem & ~list_low) == '0);
                        n_scan           = r_scan & ~list_low;
                        if ((list_rem & ~list_low) == '0) begin
                            n_state = BK_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_SIZE: begin
                    n_max = i_cfg_data;
                end
                CFG_INIT_SIZE: begin
                    n_cap    = init_cap;
                    n_used   = '0;
                    n_active = '0;
                end
                default: begin
                    n_max = r_max;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_used      <= '0;
            r_cap       <= '0;
            r_active    <= '0;
            r_max       <= MAX_SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cap       <= n_cap;
            r_active    <= n_active;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_scan <= n_scan;
        r_out  <= n_out;
    end

endmodule

FILE: hw/rtl/index_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// Index pool allocator core
// Acquire and release: queued, then run one at a time by the back-end sequencer.
// A list request gives one result per in-use index (at least one result).
// Reset is synchronous, active low: empty pool, capacity 0, max_size 64, no results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module index_pool_allocator_core
    import ipa_pkg::*;
#(
    parameter int POOL_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ipa_req_if.sink           i_req,
    ipa_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic [CFGA_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

`include "index_pool_allocator_core_assert.svh"

    t_q2b    q2b;
    logic    pop;
    logic    out_valid;
    t_result out_data;

    ipa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_q     (q2b),
        .i_pop   (pop)
    );

    ipa_back #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q2b),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_out       (out_data)
    );

    assign o_rsp.valid         = out_valid;
    assign o_rsp.status        = out_data.status;
    assign o_rsp.slot_index    = out_data.slot_index;
    assign o_rsp.active_total  = out_data.active_total;
    assign o_rsp.pool_capacity = out_data.pool_capacity;
    assign o_rsp.last          = out_data.last;

    `IPA_ASSERT_IMPLY(a_active_le_cap, i_clk, i_rst_n, o_rsp.valid, (o_rsp.active_total <= o_rsp.pool_capacity), "active count exceeds capacity")
    `IPA_ASSERT_IMPLY(a_ok_index_in_pool, i_clk, i_rst_n, (o_rsp.valid && o_rsp.status == ST_OK), ({1'b0, o_rsp.slot_index} < o_rsp.pool_capacity), "granted or listed index outside capacity")
    `IPA_ASSERT_IMPLY(a_fail_is_last, i_clk, i_rst_n, (o_rsp.valid && o_rsp.status != ST_OK), o_rsp.last, "failure result not marked last")
    `IPA_ASSERT_NEXT(a_list_keeps_cap, i_clk, i_rst_n, (o_rsp.valid && o_rsp.ready && !o_rsp.last), $stable(o_rsp.pool_capacity), "capacity changed during a list")

endmodule
